// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit arena allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int STORE_DEPTH   = 4096;
  localparam int ADDR_W        = 12;
  localparam int HDR_W         = 13;
  localparam int SIZE_W        = 13;
  localparam int ARENA_DEFAULT = 4096;

  // header layout: {used, next offset}
  localparam int HDR_USED_BIT = 12;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SIZE     = 3'd1,
    ST_NO_SPACE     = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_NOT_FREEABLE = 3'd4
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [HDR_W-1:0]  wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/ffa_mem.sv =====
// ----------------------------------------------------------------------------
// ffa_mem
// Header store: 4096 x 13 synchronous RAM, one read and one write port,
// registered read. Entry zero reads as zero until first written.
// ----------------------------------------------------------------------------
module ffa_mem (
  input  logic                             clk,
  input  logic                             rst,
  input  ffa_pkg::mem_req_t                req,
  output logic [ffa_pkg::HDR_W-1:0]        rd_data
);
  import ffa_pkg::*;

  logic [HDR_W-1:0] mem [STORE_DEPTH];
  logic [HDR_W-1:0] rd_q;
  logic             rd_mask;
  logic             zero_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q    <= mem[req.rd_addr];
      rd_mask <= (req.rd_addr == '0) && !zero_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_valid <= 1'b0;
    end else if (req.wr_en && req.wr_addr == '0) begin
      zero_valid <= 1'b1;
    end
  end

  assign rd_data = rd_mask ? '0 : rd_q;

endmodule

// ===== rtl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl
// Chain walker: reads one header per cycle, decides allocate / free, and
// writes back up to two headers before posting the result.
// ----------------------------------------------------------------------------
module ffa_ctrl #(
  parameter int ARENA_BYTES = ffa_pkg::ARENA_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic                             kind,
  input  logic [ffa_pkg::SIZE_W-1:0]       request_size,
  input  logic [ffa_pkg::SIZE_W-1:0]       payload_offset,
  input  logic                             out_free,
  output logic                             res_valid,
  output ffa_pkg::result_t                 res,
  output ffa_pkg::mem_req_t                req,
  input  logic [ffa_pkg::HDR_W-1:0]        rd_data
);
  import ffa_pkg::*;

  localparam int          STEP_W  = $clog2(ARENA_BYTES);
  localparam logic [13:0] ARENA_L = 14'(ARENA_BYTES);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ARENA_BYTES - 1);

  typedef enum logic [2:0] {IDLE, EVAL, FNXT, WR2, RESP} state_t;

  state_t             state;
  logic               kind_q;
  logic [SIZE_W-1:0]  size_q;
  logic [ADDR_W-1:0]  target;
  logic [ADDR_W-1:0]  cur;
  logic [ADDR_W-1:0]  prev;
  logic               prev_used;
  logic [ADDR_W-1:0]  link;
  logic [STEP_W-1:0]  steps;
  logic [ADDR_W-1:0]  wr2_addr;
  logic [HDR_W-1:0]   wr2_data;
  logic [ADDR_W-1:0]  res_grant;
  status_t            res_status;

  // header fields of the entry just read
  logic               used;
  logic [ADDR_W-1:0]  nxt;
  logic [13:0]        span;
  logic [ADDR_W-1:0]  split_at;
  logic [ADDR_W-1:0]  merged;

  // decision in EVAL / FNXT
  logic               ev_done;
  status_t            ev_status;
  logic               ev_wr2;
  logic [ADDR_W-1:0]  ev_wr2_addr;
  logic [HDR_W-1:0]   ev_wr2_data;
  logic               ev_adv;
  logic               ev_fnxt;
  logic               in_bad;

  assign used     = rd_data[HDR_USED_BIT];
  assign nxt      = rd_data[ADDR_W-1:0];
  assign span     = 14'(cur) + 14'(size_q);
  assign split_at = ADDR_W'(span + 14'd2);
  assign merged   = used ? link : nxt;

  assign in_bad = (kind == KIND_ALLOC) ?
                  (request_size == '0 || 14'(request_size) > ARENA_L - 14'd2) :
                  (payload_offset < 13'd2 || 14'(payload_offset) >= ARENA_L);

  always_comb begin
    req         = '0;
    ev_done     = 1'b0;
    ev_status   = ST_OK;
    ev_wr2      = 1'b0;
    ev_wr2_addr = '0;
    ev_wr2_data = '0;
    ev_adv      = 1'b0;
    ev_fnxt     = 1'b0;
    case (state)
      IDLE: begin
        req.rd_en   = s_tvalid && !in_bad;
        req.rd_addr = '0;
      end
      EVAL: begin
        if (kind_q == KIND_ALLOC) begin
          if (cur == '0 && rd_data == '0) begin
            // unformatted (or fully freed) arena
            ev_done     = 1'b1;
            req.wr_en   = 1'b1;
            req.wr_addr = '0;
            if (14'(size_q) + 14'd4 < ARENA_L) begin
              req.wr_data = {1'b1, ADDR_W'(14'(size_q) + 14'd2)};
              ev_wr2      = 1'b1;
              ev_wr2_addr = ADDR_W'(14'(size_q) + 14'd2);
            end else begin
              req.wr_data = {1'b1, {ADDR_W{1'b0}}};
            end
          end else if (!used && nxt == '0 && span + 14'd3 < ARENA_L) begin
            ev_done     = 1'b1;
            req.wr_en   = 1'b1;
            req.wr_addr = cur;
            req.wr_data = {1'b1, split_at};
            ev_wr2      = 1'b1;
            ev_wr2_addr = split_at;
          end else if (!used && nxt == '0 && span + 14'd1 < ARENA_L) begin
            ev_done     = 1'b1;
            req.wr_en   = 1'b1;
            req.wr_addr = cur;
            req.wr_data = {1'b1, {ADDR_W{1'b0}}};
          end else if (!used && nxt != '0 && span + 14'd4 < 14'(nxt)) begin
            ev_done     = 1'b1;
            req.wr_en   = 1'b1;
            req.wr_addr = cur;
            req.wr_data = {1'b1, split_at};
            ev_wr2      = 1'b1;
            ev_wr2_addr = split_at;
            ev_wr2_data = {1'b0, nxt};
          end else if (!used && nxt != '0 && span + 14'd1 < 14'(nxt)) begin
            ev_done     = 1'b1;
            req.wr_en   = 1'b1;
            req.wr_addr = cur;
            req.wr_data = {1'b1, nxt};
          end else if (nxt == '0 || steps == STEP_LAST) begin
            ev_done   = 1'b1;
            ev_status = ST_NO_SPACE;
          end else begin
            ev_adv      = 1'b1;
            req.rd_en   = 1'b1;
            req.rd_addr = nxt;
          end
        end else begin
          if (cur == target) begin
            if (!used) begin
              ev_done   = 1'b1;
              ev_status = ST_NOT_FREEABLE;
            end else if (nxt != '0) begin
              // need the next header to decide on a forward merge
              ev_fnxt     = 1'b1;
              req.rd_en   = 1'b1;
              req.rd_addr = nxt;
            end else begin
              ev_done     = 1'b1;
              req.wr_en   = 1'b1;
              req.wr_addr = cur;
              req.wr_data = '0;
              ev_wr2      = !prev_used;
              ev_wr2_addr = prev;
            end
          end else if (nxt == '0 || steps == STEP_LAST) begin
            ev_done   = 1'b1;
            ev_status = ST_NOT_FREEABLE;
          end else begin
            ev_adv      = 1'b1;
            req.rd_en   = 1'b1;
            req.rd_addr = nxt;
          end
        end
      end
      FNXT: begin
        ev_done     = 1'b1;
        req.wr_en   = 1'b1;
        req.wr_addr = cur;
        req.wr_data = {1'b0, merged};
        ev_wr2      = !prev_used;
        ev_wr2_addr = prev;
        ev_wr2_data = {1'b0, merged};
      end
      WR2: begin
        req.wr_en   = 1'b1;
        req.wr_addr = wr2_addr;
        req.wr_data = wr2_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            kind_q     <= kind;
            size_q     <= request_size;
            target     <= ADDR_W'(payload_offset - 13'd2);
            cur        <= '0;
            prev       <= '0;
            prev_used  <= 1'b1;
            steps      <= '0;
            res_grant  <= '0;
            res_status <= in_bad ?
                          ((kind == KIND_ALLOC) ? ST_BAD_SIZE : ST_OUT_OF_RANGE) :
                          ST_OK;
            state      <= in_bad ? RESP : EVAL;
          end
        end
        EVAL: begin
          wr2_addr <= ev_wr2_addr;
          wr2_data <= ev_wr2_data;
          if (ev_adv) begin
            prev      <= cur;
            prev_used <= used;
            cur       <= nxt;
            steps     <= steps + STEP_W'(1);
          end else if (ev_fnxt) begin
            link  <= nxt;
            state <= FNXT;
          end else if (ev_done) begin
            res_status <= ev_status;
            if (kind_q == KIND_ALLOC && ev_status == ST_OK) begin
              res_grant <= cur + 12'd2;
            end
            state <= ev_wr2 ? WR2 : RESP;
          end
        end
        FNXT: begin
          wr2_addr <= ev_wr2_addr;
          wr2_data <= ev_wr2_data;
          state    <= ev_wr2 ? WR2 : RESP;
        end
        WR2: begin
          state <= RESP;
        end
        RESP: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign s_tready    = (state == IDLE);
  assign res_valid   = (state == RESP) && out_free;
  assign res.granted = res_grant;
  assign res.status  = res_status;

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.rd_en && req.wr_en))
    else $error("header read and write issued together");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && s_tvalid) |=> (state == EVAL || state == RESP))
    else $error("accepted item did not start");

  a_error_zero_grant: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_OK) |-> (res.granted == '0))
    else $error("error result carries an offset");

  a_wr2_after_wr: assert property (@(posedge clk) disable iff (rst)
    (state == WR2) |-> $past(req.wr_en))
    else $error("second header write without first");

endmodule

// ===== rtl/first_fit_arena_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_top
// First-fit allocator over a byte arena kept as a chain of block headers.
// ----------------------------------------------------------------------------
// Input channel (s_*): one item is an allocate (tuser = 0, size in tdata) or
// a free (tuser = 1, payload offset in tdata). Output channel (m_*): exactly
// one result item per input item, granted offset and status.
// The header-zero read issued at acceptance returns in the first
// walk cycle, and the walk reads one header per cycle (the header RAM has a
// single read port and a registered read). The first header write shares
// the last walk cycle; a free that checks its next block passes through
// the FNXT state, a second header write goes through the WR2 state, and
// the result is posted from the RESP state. s_tready is back high in the
// cycle in which m_tvalid rises. Items are handled one at a time; s_tready
// is high only while the walker is idle. A bad size or out-of-range offset
// skips the walk and goes straight to RESP to post its result.
// Reset clears control state and marks header zero empty, so the first
// allocate formats the arena; the rest of the RAM is not cleared.
// The result sits in an output register; the walker accepts the next item
// while it waits, and stalls before posting a result until it is taken.
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_top #(
  parameter int ARENA_BYTES = ffa_pkg::ARENA_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // request_size[12:0], payload_offset[25:13]
  input  logic [0:0]  s_tuser,   // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // granted_offset[11:0], status[14:12]
);
  import ffa_pkg::*;

  mem_req_t         req;
  logic [HDR_W-1:0] rd_data;
  result_t          res;
  logic             res_valid;
  logic             out_free;
  result_t          out_q;

  assign out_free = !m_tvalid || m_tready;

  ffa_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  ffa_ctrl #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .kind           (s_tuser[0]),
    .request_size   (s_tdata[12:0]),
    .payload_offset (s_tdata[25:13]),
    .out_free       (out_free),
    .res_valid      (res_valid),
    .res            (res),
    .req            (req),
    .rd_data        (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {1'b0, out_q.status, out_q.granted};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the first-fit arena allocator.
// Allocate and free items go in through the slave port. A mirror of the
// header chain predicts the granted offset and status of each item, and
// every result item is compared against the oldest prediction. Directed
// corner cases run first, then random alloc/free traffic that tracks live
// blocks, in three phases with different sender and receiver stall rates.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffa_pkg::*;

  localparam int ARENA_BYTES = 4096;
  localparam int WATCHDOG_CYCLES = 40000;
  localparam int PHASE_ITEMS = 460;

  // mirror of the header chain plus the queue of predicted results
  class arena_scoreboard;
    logic [HDR_W-1:0] hdr [0:STORE_DEPTH-1];
    result_t pending [$];
    int errors;
    int results_seen;
    int status_seen [5];

    function new();
      foreach (hdr[i]) hdr[i] = '0;
      errors = 0;
      results_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void put_hdr(int at, logic used, int nxt);
      hdr[at & 12'hfff] = {used, 12'(nxt)};
    endfunction

    function result_t predict_alloc(int size);
      result_t r;
      logic [HDR_W-1:0] h;
      int cur;
      int n;
      r.granted = '0;
      r.status = ST_OK;
      if (size < 1 || size > ARENA_BYTES - 2) begin
        r.status = ST_BAD_SIZE;
        return r;
      end
      h = hdr[0];
      // empty arena: block 0 takes the request, tail follows if it fits
      if (h == '0) begin
        if (size < ARENA_BYTES - 4) begin
          put_hdr(0, 1'b1, size + 2);
          put_hdr(size + 2, 1'b0, 0);
        end else begin
          put_hdr(0, 1'b1, 0);
        end
        r.granted = 12'd2;
        return r;
      end
      cur = 0;
      for (int steps = 0; steps < ARENA_BYTES; steps++) begin
        n = int'(h[ADDR_W-1:0]);
        if (!h[HDR_USED_BIT]) begin
          if (n == 0) begin
            if (size < ARENA_BYTES - 3 - cur) begin
              put_hdr(cur, 1'b1, cur + size + 2);
              put_hdr(cur + size + 2, 1'b0, 0);
              r.granted = 12'(cur + 2);
              return r;
            end
            if (size < ARENA_BYTES - 1 - cur) begin
              put_hdr(cur, 1'b1, 0);
              r.granted = 12'(cur + 2);
              return r;
            end
            break;
          end
          if (size < n - cur - 4) begin
            put_hdr(cur, 1'b1, cur + size + 2);
            put_hdr(cur + size + 2, 1'b0, n);
            r.granted = 12'(cur + 2);
            return r;
          end
          if (size < n - cur - 1) begin
            put_hdr(cur, 1'b1, n);
            r.granted = 12'(cur + 2);
            return r;
          end
        end
        cur = n;
        if (cur == 0) break;
        h = hdr[cur];
      end
      r.status = ST_NO_SPACE;
      return r;
    endfunction

    function result_t predict_free(int p);
      result_t r;
      logic [HDR_W-1:0] h;
      int target;
      int cur;
      int prev;
      int n;
      int nv;
      logic prev_used;
      r.granted = '0;
      r.status = ST_OK;
      if (p < 2 || p - 2 > ARENA_BYTES - 3) begin
        r.status = ST_OUT_OF_RANGE;
        return r;
      end
      target = p - 2;
      cur = 0;
      prev = 0;
      h = hdr[0];
      prev_used = h[HDR_USED_BIT];
      for (int steps = 0; steps < ARENA_BYTES; steps++) begin
        n = int'(h[ADDR_W-1:0]);
        if (cur == target) begin
          if (!h[HDR_USED_BIT]) break;
          nv = n;
          if (n != 0 && !hdr[n][HDR_USED_BIT]) nv = int'(hdr[n][ADDR_W-1:0]);
          put_hdr(cur, 1'b0, nv);
          if (!prev_used) put_hdr(prev, 1'b0, nv);
          return r;
        end
        prev = cur;
        prev_used = h[HDR_USED_BIT];
        cur = n;
        if (cur == 0) break;
        h = hdr[cur];
      end
      r.status = ST_NOT_FREEABLE;
      return r;
    endfunction

    function result_t note_request(logic kind, int size, int off);
      result_t r;
      if (kind == KIND_ALLOC) r = predict_alloc(size);
      else r = predict_free(off);
      pending.push_back(r);
      status_seen[int'(r.status)]++;
      return r;
    endfunction

    function void check_reply(logic [ADDR_W-1:0] granted, logic [2:0] status);
      result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item: granted=%0d status=%0d",
                 $time, granted, status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (granted !== want.granted || status !== want.status) begin
        $display("%0t: mismatch: expected granted=%0d status=%0d, got granted=%0d status=%0d",
                 $time, want.granted, want.status, granted, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // request_size[12:0], payload_offset[25:13]
  logic [0:0]  s_tuser;   // kind[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // granted_offset[11:0], status[14:12]

  arena_scoreboard book;
  int src_idle_pct;
  int sink_idle_pct;
  int live_q [$];
  int last_freed;
  int idle_cycles;

  first_fit_arena_allocator_top #(.ARENA_BYTES(ARENA_BYTES)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_reply(m_tdata[11:0], m_tdata[14:12]);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic kind, input int size, input int off);
    result_t r;
    int idx [$];
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, 13'(off), 13'(size)};
    do @(posedge clk); while (!s_tready);
    r = book.note_request(kind, size, off);
    if (r.status == ST_OK) begin
      if (kind == KIND_ALLOC) begin
        live_q.push_back(int'(r.granted));
      end else begin
        idx = live_q.find_first_index(x) with (x == off);
        if (idx.size() > 0) live_q.delete(idx[0]);
        last_freed = off;
      end
    end
    @(negedge clk);
  endtask

  task automatic send_alloc(input int size);
    send_request(KIND_ALLOC, size, $urandom_range(8191));
  endtask

  task automatic send_free(input int off);
    send_request(KIND_FREE, $urandom_range(8191), off);
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (book.pending.size() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_traffic(input int count);
    int pick;
    int size;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      // keep the chain short enough that walks stay cheap
      if (live_q.size() > 48) pick = (pick < 70) ? 60 : pick;
      if (pick < 50 || (pick < 85 && live_q.size() == 0)) begin
        pick = $urandom_range(99);
        if (pick < 70) size = $urandom_range(48, 1);
        else if (pick < 85) size = $urandom_range(600, 49);
        else if (pick < 92) size = $urandom_range(ARENA_BYTES - 2, 601);
        else if (pick < 97) size = $urandom_range(8191, ARENA_BYTES - 1);
        else size = 0;
        send_alloc(size);
      end else if (pick < 85) begin
        send_free(live_q[$urandom_range(live_q.size() - 1)]);
      end else if (pick < 92) begin
        send_free($urandom_range(8191));
      end else if (pick < 96) begin
        send_free(last_freed);
      end else begin
        send_free($urandom_range(ARENA_BYTES - 1, 2));
      end
    end
  endtask

  initial begin
    book = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    idle_cycles = 0;
    last_freed = 2;
    src_idle_pct = 26;
    sink_idle_pct = 54;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unformatted arena, range checks
    send_free(2);
    send_free(0);
    send_free(1);
    send_free(ARENA_BYTES);
    send_free(8191);
    send_alloc(0);
    send_alloc(ARENA_BYTES - 1);
    send_alloc(8191);
    // whole-arena grab, then full, then release back to empty
    send_alloc(ARENA_BYTES - 2);
    send_alloc(1);
    send_free(2);
    // tail too small to split: taken whole; double free; merge into empty
    send_alloc(ARENA_BYTES - 5);
    send_alloc(1);
    send_free(ARENA_BYTES - 1);
    send_free(ARENA_BYTES - 1);
    send_free(2);
    send_alloc(ARENA_BYTES - 4);
    send_free(2);
    // header placed past the end of usable space
    send_alloc(10);
    send_alloc(ARENA_BYTES - 16);
    send_alloc(1);
    send_free(14);
    send_free(100);
    send_alloc(1);
    send_free(2);
    send_free(14);

    random_traffic(PHASE_ITEMS);
    wait_drained();
    src_idle_pct = 54;
    sink_idle_pct = 26;
    random_traffic(PHASE_ITEMS);
    wait_drained();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    random_traffic(PHASE_ITEMS);
    wait_drained();
    repeat (50) @(posedge clk);

    $display("tb: %0d results checked; ok %0d, bad size %0d, no space %0d",
             book.results_seen, book.status_seen[0], book.status_seen[1],
             book.status_seen[2]);
    $display("tb: out of range %0d, not freeable %0d, %0d blocks still live",
             book.status_seen[3], book.status_seen[4], live_q.size());
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
